// ----- rtl/utv_pkg.sv -----
`timescale 1ns / 1ps
// utv_pkg: shared constants, types and helpers for the utc timestamp validator
// no dependencies

package utv_pkg;

  localparam int unsigned MAX_TEXT_LEN = 32;
  localparam int unsigned POS_W        = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned YEAR_W       = 14;
  localparam int unsigned FIELD_W      = 7;

  localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_TEXT_LEN - 1);
  localparam logic [POS_W-1:0] POS_MAX      = POS_W'(MAX_TEXT_LEN);
  localparam logic [POS_W-1:0] BASE_LEN     = POS_W'(20);
  localparam logic [POS_W-1:0] FRAC_MIN_LEN = POS_W'(22);
  localparam logic [POS_W-1:0] FRAC_MAX_LEN = POS_W'(30);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Z     = 8'h5a;

  localparam logic [FIELD_W-1:0] MONTH_MAX  = FIELD_W'(12);
  localparam logic [FIELD_W-1:0] MONTH_FEB  = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] HOUR_MAX   = FIELD_W'(23);
  localparam logic [FIELD_W-1:0] MINSEC_MAX = FIELD_W'(59);
  localparam logic [FIELD_W-1:0] LEAP_FEB   = FIELD_W'(29);

  // parsed string handed from the parser to the range checker
  typedef struct packed {
    logic               fmt_good;
    logic [POS_W-1:0]   len;
    logic [7:0]         last_char;
    logic               year_nz;
    logic               leap;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } utv_snap_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [FIELD_W-1:0] month_len(input logic [FIELD_W-1:0] m);
    logic [FIELD_W-1:0] r;
    unique case (m)
      FIELD_W'(2):                                         r = FIELD_W'(28);
      FIELD_W'(4), FIELD_W'(6), FIELD_W'(9), FIELD_W'(11): r = FIELD_W'(30);
      default:                                             r = FIELD_W'(31);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/utv_parse.sv -----
`timescale 1ns / 1ps
// utv_parse: input register, per-character position counter, digit accumulators
// and format flags; emits a snapshot of the parsed string on the last character
// depends on utv_pkg

module utv_parse import utv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       snap_valid_o,
  input  logic       snap_ready_i,
  output utv_snap_t  snap_o
);

  logic               s1_valid_q;
  logic [7:0]         s1_char_q;
  logic               s1_last_q;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic               term_q, term_d;
  logic               fmt_q, fmt_d;
  logic [7:0]         prev_q, prev_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [FIELD_W-1:0] month_q, month_d;
  logic [FIELD_W-1:0] day_q, day_d;
  logic [FIELD_W-1:0] hour_q, hour_d;
  logic [FIELD_W-1:0] minute_q, minute_d;
  logic [FIELD_W-1:0] second_q, second_d;
  logic               yy_zero_q, yy_zero_d;
  logic [1:0]         cent_q, cent_d;

  logic               snap_valid_q;
  utv_snap_t          snap_q, snap_d;

  logic               snap_free;
  logic               fire;
  logic               in_acc;
  logic               dig_ok;
  logic [3:0]         dig;
  logic [YEAR_W+3:0]  year_w;
  logic [FIELD_W+3:0] fld_w;
  logic [FIELD_W-1:0] fld_src;

  assign snap_free  = !snap_valid_q || snap_ready_i;
  assign fire       = s1_valid_q && (!s1_last_q || snap_free);
  assign in_ready_o = !s1_valid_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;
  assign dig_ok     = is_digit(s1_char_q);
  assign dig        = s1_char_q[3:0];

  always_comb begin
    unique case (pos_q)
      POS_W'(5), POS_W'(6):   fld_src = month_q;
      POS_W'(8), POS_W'(9):   fld_src = day_q;
      POS_W'(11), POS_W'(12): fld_src = hour_q;
      POS_W'(14), POS_W'(15): fld_src = minute_q;
      default:                fld_src = second_q;
    endcase
    year_w = (YEAR_W+4)'(year_q) * (YEAR_W+4)'(10) + (YEAR_W+4)'(dig);
    fld_w  = (FIELD_W+4)'(fld_src) * (FIELD_W+4)'(10) + (FIELD_W+4)'(dig);
  end

  always_comb begin
    pos_d     = pos_q;
    term_d    = term_q;
    fmt_d     = fmt_q;
    prev_d    = prev_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    yy_zero_d = yy_zero_q;
    cent_d    = cent_q;
    if (!term_q) begin
      if (s1_char_q == CHAR_NUL) begin
        term_d = 1'b1;
      end else if (pos_q >= POS_LIMIT) begin
        fmt_d  = 1'b0;
        prev_d = s1_char_q;
      end else begin
        unique case (pos_q)
          POS_W'(0), POS_W'(1), POS_W'(2), POS_W'(3): begin
            if (!dig_ok) begin
              fmt_d = 1'b0;
            end else begin
              year_d = year_w[YEAR_W-1:0];
              unique case (pos_q[1:0])
                2'd0:    cent_d = dig[1:0];
                2'd1:    cent_d = {cent_q[0], 1'b0} + dig[1:0];
                2'd2:    yy_zero_d = (dig == 4'd0);
                default: yy_zero_d = yy_zero_q && (dig == 4'd0);
              endcase
            end
          end
          POS_W'(5), POS_W'(6): begin
            if (!dig_ok) fmt_d = 1'b0;
            else month_d = fld_w[FIELD_W-1:0];
          end
          POS_W'(8), POS_W'(9): begin
            if (!dig_ok) fmt_d = 1'b0;
            else day_d = fld_w[FIELD_W-1:0];
          end
          POS_W'(11), POS_W'(12): begin
            if (!dig_ok) fmt_d = 1'b0;
            else hour_d = fld_w[FIELD_W-1:0];
          end
          POS_W'(14), POS_W'(15): begin
            if (!dig_ok) fmt_d = 1'b0;
            else minute_d = fld_w[FIELD_W-1:0];
          end
          POS_W'(17), POS_W'(18): begin
            if (!dig_ok) fmt_d = 1'b0;
            else second_d = fld_w[FIELD_W-1:0];
          end
          POS_W'(4), POS_W'(7): begin
            if (s1_char_q != CHAR_DASH) fmt_d = 1'b0;
          end
          POS_W'(10): begin
            if (s1_char_q != CHAR_T) fmt_d = 1'b0;
          end
          POS_W'(13), POS_W'(16): begin
            if (s1_char_q != CHAR_COLON) fmt_d = 1'b0;
          end
          POS_W'(19): begin
          end
          POS_W'(20): begin
            // offset 19 must be the fraction point
            if (prev_q != CHAR_DOT) fmt_d = 1'b0;
          end
          default: begin
            // previous character sits inside the fraction
            if (!is_digit(prev_q)) fmt_d = 1'b0;
          end
        endcase
        pos_d  = pos_q + POS_W'(1);
        prev_d = s1_char_q;
      end
    end
  end

  always_comb begin
    snap_d.fmt_good  = fmt_d;
    snap_d.len       = pos_d;
    snap_d.last_char = prev_d;
    snap_d.year_nz   = (year_d != '0);
    // divisible by 4, and a century year only when the century is divisible by 4
    snap_d.leap      = (year_d[1:0] == 2'd0) && (!yy_zero_d || (cent_d == 2'd0));
    snap_d.month     = month_d;
    snap_d.day       = day_d;
    snap_d.hour      = hour_d;
    snap_d.minute    = minute_d;
    snap_d.second    = second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      snap_valid_q <= 1'b0;
      pos_q        <= '0;
      term_q       <= 1'b0;
      fmt_q        <= 1'b1;
      prev_q       <= '0;
      year_q       <= '0;
      month_q      <= '0;
      day_q        <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      yy_zero_q    <= 1'b0;
      cent_q       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire && s1_last_q) begin
        snap_valid_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
      if (fire) begin
        if (s1_last_q) begin
          pos_q     <= '0;
          term_q    <= 1'b0;
          fmt_q     <= 1'b1;
          prev_q    <= '0;
          year_q    <= '0;
          month_q   <= '0;
          day_q     <= '0;
          hour_q    <= '0;
          minute_q  <= '0;
          second_q  <= '0;
          yy_zero_q <= 1'b0;
          cent_q    <= '0;
        end else begin
          pos_q     <= pos_d;
          term_q    <= term_d;
          fmt_q     <= fmt_d;
          prev_q    <= prev_d;
          year_q    <= year_d;
          month_q   <= month_d;
          day_q     <= day_d;
          hour_q    <= hour_d;
          minute_q  <= minute_d;
          second_q  <= second_d;
          yy_zero_q <= yy_zero_d;
          cent_q    <= cent_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= in_char_i;
      s1_last_q <= in_last_i;
    end
    if (fire && s1_last_q) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ----- rtl/utv_check.sv -----
`timescale 1ns / 1ps
// utv_check: length, terminator and calendar range checks on a parsed string,
// result held in the output register
// depends on utv_pkg

module utv_check import utv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      snap_valid_i,
  output logic      snap_ready_o,
  input  utv_snap_t snap_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      out_ok_o
);

  logic               out_valid_q;
  logic               ok_q, ok_d;
  logic [FIELD_W-1:0] max_day;
  logic               len_ok;
  logic               range_ok;

  assign snap_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    max_day = month_len(snap_i.month);
    if ((snap_i.month == MONTH_FEB) && snap_i.leap) max_day = LEAP_FEB;
    len_ok = (snap_i.len < POS_MAX) &&
             ((snap_i.len == BASE_LEN) ||
              ((snap_i.len >= FRAC_MIN_LEN) && (snap_i.len <= FRAC_MAX_LEN)));
    range_ok = snap_i.year_nz && (snap_i.month != '0) && (snap_i.month <= MONTH_MAX) &&
               (snap_i.day != '0) && (snap_i.hour <= HOUR_MAX) &&
               (snap_i.minute <= MINSEC_MAX) && (snap_i.second <= MINSEC_MAX);
    ok_d = snap_i.fmt_good && len_ok && (snap_i.last_char == CHAR_Z) && range_ok &&
           (snap_i.day <= max_day);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      ok_q <= ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = ok_q;

endmodule

// ----- rtl/utc_timestamp_validator.sv -----
`timescale 1ns / 1ps
// utc_timestamp_validator: top level of the utc timestamp checker
// depends on utv_pkg, utv_parse, utv_check
//
//   channel  direction  tdata (lsb up)         tuser  tlast
//   s_axis   in         character[7:0]         -      last
//   m_axis   out        timestamp_ok, 7'b0     -      -
//
// one character per cycle, back to back, unless a last character waits on the
// snapshot register; each transaction passes the input register, then updates
// the counter and accumulators; a string marked last gives one result, which
// passes the snapshot register and is held valid in the output register
// reset clears the pipeline and the parse state; no clearing pass
// a stalled result holds in the output register, one more finished string waits
// in the snapshot register, and the next last character then stalls the input

module utc_timestamp_validator import utv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // character[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // timestamp_ok[0], zero[7:1]
);

  utv_snap_t snap;
  logic      snap_valid;
  logic      snap_ready;
  logic      ok;

  utv_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  utv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_ok_o     (ok)
  );

  assign m_axis_tdata = {7'b0, ok};

endmodule

// ----- rtl/utv_checker.sv -----
`timescale 1ns / 1ps
// utv_checker: port-level assertions for utc_timestamp_validator, bound to the top
// depends on utc_timestamp_validator

module utv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a result leaves only through a transaction
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without transaction");

  // padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

  // input never stalls while the output register is empty
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // an offered character waits unchanged until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input changed while stalled");

endmodule

bind utc_timestamp_validator utv_checker u_utv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_utc_timestamp_validator.sv -----
`timescale 1ns / 1ps
// tb_utc_timestamp_validator: self-checking testbench for the utc timestamp validator
// streams timestamp strings one character per transaction and checks each verdict
// depends on utv_pkg and utc_timestamp_validator

module tb_utc_timestamp_validator;
  import utv_pkg::*;

  typedef logic [7:0] char_q_t[$];

  // running copy of the parser state, predicts one verdict per string
  class ts_verdict_board;
    logic [7:0]         verdict_q[$];
    int                 errors;
    int                 shown;
    logic [POS_W-1:0]   pos;
    bit                 ended;
    bit                 fmt_ok;
    logic [7:0]         prev_ch;
    logic [YEAR_W-1:0]  year_acc;
    logic [FIELD_W-1:0] month_acc;
    logic [FIELD_W-1:0] day_acc;
    logic [FIELD_W-1:0] hour_acc;
    logic [FIELD_W-1:0] minute_acc;
    logic [FIELD_W-1:0] second_acc;

    function new();
      errors = 0;
      shown  = 0;
      clear();
    endfunction

    function void clear();
      pos        = '0;
      ended      = 1'b0;
      fmt_ok     = 1'b1;
      prev_ch    = CHAR_NUL;
      year_acc   = '0;
      month_acc  = '0;
      day_acc    = '0;
      hour_acc   = '0;
      minute_acc = '0;
      second_acc = '0;
    endfunction

    function bit digit_char(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function int unsigned push_digit(int unsigned acc, logic [7:0] c);
      if (!digit_char(c)) begin
        fmt_ok = 1'b0;
        return acc;
      end
      return acc * 10 + (c - CHAR_ZERO);
    endfunction

    function void absorb(logic [7:0] c);
      if (pos >= POS_LIMIT) begin
        fmt_ok  = 1'b0;
        prev_ch = c;
        return;
      end
      case (pos)
        0, 1, 2, 3: year_acc   = YEAR_W'(push_digit(year_acc, c));
        5, 6:       month_acc  = FIELD_W'(push_digit(month_acc, c));
        8, 9:       day_acc    = FIELD_W'(push_digit(day_acc, c));
        11, 12:     hour_acc   = FIELD_W'(push_digit(hour_acc, c));
        14, 15:     minute_acc = FIELD_W'(push_digit(minute_acc, c));
        17, 18:     second_acc = FIELD_W'(push_digit(second_acc, c));
        4, 7:       if (c != CHAR_DASH) fmt_ok = 1'b0;
        10:         if (c != CHAR_T) fmt_ok = 1'b0;
        13, 16:     if (c != CHAR_COLON) fmt_ok = 1'b0;
        19:         ;
        20:         if (prev_ch != CHAR_DOT) fmt_ok = 1'b0;
        default:    if (!digit_char(prev_ch)) fmt_ok = 1'b0;
      endcase
      pos     = pos + 1'b1;
      prev_ch = c;
    endfunction

    function bit verdict();
      int unsigned lim;
      bit          leap_yr;
      if (!fmt_ok) return 1'b0;
      if (pos >= POS_MAX) return 1'b0;
      if (!(pos == BASE_LEN || (pos >= FRAC_MIN_LEN && pos <= FRAC_MAX_LEN))) return 1'b0;
      if (prev_ch != CHAR_Z) return 1'b0;
      if (year_acc == 0 || month_acc == 0 || month_acc > MONTH_MAX || day_acc == 0 ||
          hour_acc > HOUR_MAX || minute_acc > MINSEC_MAX || second_acc > MINSEC_MAX)
        return 1'b0;
      leap_yr = (year_acc % 4 == 0) && ((year_acc % 100 != 0) || (year_acc % 400 == 0));
      case (month_acc)
        2:             lim = leap_yr ? 29 : 28;
        4, 6, 9, 11:   lim = 30;
        default:       lim = 31;
      endcase
      return day_acc <= lim;
    endfunction

    function void note_char(logic [7:0] c, bit last);
      if (!ended) begin
        if (c == CHAR_NUL) ended = 1'b1;
        else absorb(c);
      end
      if (last) begin
        verdict_q.push_back({7'b0, verdict()});
        clear();
      end
    endfunction

    function void check_verdict(logic [7:0] got);
      logic [7:0] want;
      if (verdict_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("%0t: result %h with no string pending", $realtime, got);
        end
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("%0t: timestamp_ok mismatch, expected %h got %h", $realtime, want, got);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // character[7:0]
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // timestamp_ok[0], zero[7:1]

  ts_verdict_board board = new();
  bit source_idle_on = 1'b1;
  bit sink_idle_on   = 1'b1;
  bit hold_req       = 1'b0;

  always #1 clk_i = ~clk_i;

  utc_timestamp_validator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic char_q_t text_of(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic char_q_t random_stamp();
    char_q_t     q;
    int unsigned yr, mo, dy, hr, mi, se, sel, n;
    sel = $urandom_range(0, 9);
    yr  = (sel == 0) ? 0 : (sel == 1) ? 400 * $urandom_range(1, 24) :
          (sel == 2) ? 100 * $urandom_range(1, 99) :
          (sel == 3) ? 4 * $urandom_range(1, 2499) : $urandom_range(1, 9999);
    mo  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    sel = $urandom_range(0, 9);
    dy  = (sel == 0) ? $urandom_range(0, 99) :
          (sel <= 4) ? $urandom_range(28, 31) : $urandom_range(1, 28);
    hr  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    se  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    q.push_back(8'(CHAR_ZERO + yr / 1000 % 10));
    q.push_back(8'(CHAR_ZERO + yr / 100 % 10));
    q.push_back(8'(CHAR_ZERO + yr / 10 % 10));
    q.push_back(8'(CHAR_ZERO + yr % 10));
    q.push_back(CHAR_DASH);
    q.push_back(8'(CHAR_ZERO + mo / 10));
    q.push_back(8'(CHAR_ZERO + mo % 10));
    q.push_back(CHAR_DASH);
    q.push_back(8'(CHAR_ZERO + dy / 10));
    q.push_back(8'(CHAR_ZERO + dy % 10));
    q.push_back(CHAR_T);
    q.push_back(8'(CHAR_ZERO + hr / 10));
    q.push_back(8'(CHAR_ZERO + hr % 10));
    q.push_back(CHAR_COLON);
    q.push_back(8'(CHAR_ZERO + mi / 10));
    q.push_back(8'(CHAR_ZERO + mi % 10));
    q.push_back(CHAR_COLON);
    q.push_back(8'(CHAR_ZERO + se / 10));
    q.push_back(8'(CHAR_ZERO + se % 10));
    sel = $urandom_range(0, 9);
    if (sel >= 4) begin
      // fraction: mostly legal lengths, sometimes empty or too long
      n = (sel <= 7) ? $urandom_range(1, 9) :
          (sel == 8) ? ($urandom_range(0, 1) ? 10 : 0) : $urandom_range(11, 20);
      q.push_back(CHAR_DOT);
      repeat (n) q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    end
    q.push_back(CHAR_Z);
    case ($urandom_range(0, 9))
      0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(1, 255));
      1: q[$urandom_range(0, q.size() - 1)] = CHAR_NUL;
      2: begin
        if ($urandom_range(0, 1)) q.push_back(CHAR_NUL);
        repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
      end
      3: q.delete($urandom_range(0, q.size() - 1));
      default: ;
    endcase
    return q;
  endfunction

  function automatic char_q_t random_noise();
    char_q_t q;
    repeat ($urandom_range(1, 45)) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic send_text(input char_q_t txt);
    for (int i = 0; i < txt.size(); i++) begin
      if (source_idle_on && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= txt[i];
      s_axis_tlast  <= (i == txt.size() - 1);
      do @(posedge clk_i); while (s_axis_tready !== 1'b1);
      board.note_char(txt[i], i == txt.size() - 1);
    end
  endtask

  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    while (board.verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int sink_stall;
    sink_stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) board.check_verdict(m_axis_tdata);
      if (hold_req) begin
        sink_stall = 300;
        hold_req   = 1'b0;
      end else if (sink_stall == 0 && sink_idle_on && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(1, 7);
      end
      if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    string   probes[$];
    char_q_t txt;
    probes = '{
      "2024-02-29T23:59:59Z", "2023-02-29T00:00:00Z", "1900-02-29T12:00:00Z",
      "2000-02-29T12:00:00Z", "0000-01-01T00:00:00Z", "9999-12-31T23:59:59.123456789Z",
      "2024-01-01T00:00:00.1Z", "2024-01-01T00:00:00.Z", "2024-01-01T00:00:00.1234567890Z",
      "2024-01-01T00:00:00.123456789012345678Z", "2024-13-01T24:60:60Z",
      "2024-04-31T00:00:00Z", "2024-00-00T00:00:00Z", "2024-01-01t00:00:00z",
      "2024-01-01 00:00:00Z", "A"
    };
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[k]) send_text(text_of(probes[k]));
    // empty string, then a valid stamp followed by a terminator and trailing junk
    txt = '{CHAR_NUL};
    send_text(txt);
    txt = text_of("2024-01-01T00:00:00Z");
    txt.push_back(CHAR_NUL);
    txt.push_back(8'hff);
    txt.push_back(CHAR_DASH);
    send_text(txt);

    // back pressure: results back up until the input stalls
    hold_req = 1'b1;
    repeat (8) begin
      txt = '{8'($urandom_range(0, 255))};
      send_text(txt);
    end
    repeat (3) send_text(random_stamp());
    drain_verdicts();

    for (int n = 0; n < 4; n++) begin
      if (n == 2) begin
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) send_text(random_noise());
      else send_text(random_stamp());
      if (n == 1) drain_verdicts();
    end

    drain_verdicts();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.verdict_q.size() == 0)
      $display("utc_timestamp_validator test passed");
    else
      $display("utc_timestamp_validator test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("utc_timestamp_validator test failed");
    $finish;
  end

endmodule
